FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the glob matcher design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked property, disabled while reset is held.
`define GWM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked property that is checked during reset as well.
`define GWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GWM_ASSERT(lbl, clk, rstn, prop, msg)
`define GWM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: design/gwm_pkg.sv
// ----------------------------------------------------------------------------
// Glob matcher package
// Operation codes, command bundle and wildcard byte constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gwm_pkg;

  // Wildcard bytes of the pattern language.
  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_SUBJECT = 2'd2,
    OP_END     = 2'd3
  } gwm_op_t;

  // One-hot command issued when the registered item is executed.
  typedef struct packed {
    logic clear;
    logic append;
    logic subject;
    logic finish;
  } gwm_cmd_t;

endpackage

FILE: design/gwm_ifs.sv
// ----------------------------------------------------------------------------
// Glob matcher channels
// Valid/ready interfaces for the item input and the result output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gwm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] character;

  modport source (output valid, output op, output character, input ready);
  modport sink   (input valid, input op, input character, output ready);
endinterface

interface gwm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_too_long;

  modport source (output valid, output matched, output pattern_too_long, input ready);
  modport sink   (input valid, input matched, input pattern_too_long, output ready);
endinterface

FILE: design/gwm_pattern_bank.sv
// ----------------------------------------------------------------------------
// Glob matcher pattern bank
// Pattern bytes with per-position wildcard flags and a fill mask; compares
// every stored position against the current subject byte in parallel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gwm_pattern_bank #(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gwm_pkg::gwm_cmd_t      cmd,
  input  logic [7:0]             ch,
  output logic                   full,
  output logic [PATTERN_MAX-1:0] valid_v,
  output logic [PATTERN_MAX-1:0] star_v,
  output logic [PATTERN_MAX-1:0] lit_hit
);
  import gwm_pkg::*;

  logic [7:0]             byte_r [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] star_r;
  logic [PATTERN_MAX-1:0] any_r;
  logic [PATTERN_MAX-1:0] valid_r;
  logic [PATTERN_MAX-1:0] valid_nxt;
  logic [PATTERN_MAX-1:0] wr_sel;
  logic                   do_write;

  // The fill mask is a thermometer; the first empty slot takes the next byte.
  assign full     = valid_r[PATTERN_MAX-1];
  assign do_write = cmd.append && !full;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
    if (i == 0) begin : g_first
      assign wr_sel[i] = !valid_r[i];
    end else begin : g_rest
      assign wr_sel[i] = !valid_r[i] && valid_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (do_write && wr_sel[i]) begin
        byte_r[i] <= ch;
        star_r[i] <= (ch == STAR_BYTE);
        any_r[i]  <= (ch == ANY_BYTE);
      end
    end

    assign lit_hit[i] = valid_r[i] && !star_r[i] && (any_r[i] || (byte_r[i] == ch));
  end

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.clear) begin
      valid_nxt = '0;
    end else if (do_write) begin
      valid_nxt = valid_r | wr_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign valid_v = valid_r;
  assign star_v  = star_r & valid_r;

endmodule

FILE: design/gwm_active_set.sv
// ----------------------------------------------------------------------------
// Glob matcher active set
// Holds the active pattern positions, applies star closure through a
// log-depth prefix network and advances the set by one subject byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gwm_active_set #(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  gwm_pkg::gwm_cmd_t      cmd,
  input  logic [PATTERN_MAX-1:0] valid_v,
  input  logic [PATTERN_MAX-1:0] star_v,
  input  logic [PATTERN_MAX-1:0] lit_hit,
  output logic                   hit
);
  import gwm_pkg::*;

  localparam int unsigned         LVLS  = $clog2(PATTERN_MAX + 1);
  localparam logic [PATTERN_MAX:0] START = {{PATTERN_MAX{1'b0}}, 1'b1};

  logic [PATTERN_MAX:0] act_r;
  logic [PATTERN_MAX:0] act_nxt;
  logic [PATTERN_MAX:0] closed;
  logic [PATTERN_MAX:0] step;
  logic [PATTERN_MAX:0] end_pos;

  // Star closure: position j is reached from an active position i <= j when
  // every position from i to j-1 holds a star. Prefix OR with propagate.
  always_comb begin
    logic [PATTERN_MAX:0] g;
    logic [PATTERN_MAX:0] p;
    g = act_r;
    p = {star_v, 1'b0};
    for (int lvl = 0; lvl < LVLS; lvl++) begin
      g = g | (p & (g << (1 << lvl)));
      p = p & (p << (1 << lvl));
    end
    closed = g;
  end

  // A star keeps its own position, a literal or '?' advances by one.
  assign step = {1'b0, closed[PATTERN_MAX-1:0] & star_v}
              | {closed[PATTERN_MAX-1:0] & lit_hit, 1'b0};

  // Position equal to the pattern length.
  assign end_pos = {valid_v, 1'b1} & ~{1'b0, valid_v};
  assign hit     = |(closed & end_pos);

  always_comb begin
    act_nxt = act_r;
    if (cmd.clear || cmd.append || cmd.finish) begin
      act_nxt = START;
    end else if (cmd.subject) begin
      act_nxt = step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= START;
    end else begin
      act_r <= act_nxt;
    end
  end

endmodule

FILE: design/glob_wildcard_matcher_core.sv
// An end-of-subject item passes through the item register and then the
// result register before its result can transfer. The core takes one item
// per cycle while no end-of-subject item is stalled in the item register.
// An end-of-subject item waits in the item register only while a result is
// still held and not taken. Reset (rst_n low, synchronous) empties both
// registers, clears the pattern and overflow flag, and activates position 0.
// ----------------------------------------------------------------------------
// Glob wildcard matcher core
// Whole-string matcher for '*' and '?' patterns, run as a bit-parallel
// automaton over the loaded pattern positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module glob_wildcard_matcher_core #(
  parameter int unsigned PATTERN_MAX = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  gwm_in_if.sink    in_chan,
  gwm_out_if.source out_chan
);
  import gwm_pkg::*;

  // Item register: the accepted item waits here until it is executed.
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  gwm_op_t    s1_op_r;
  logic [7:0] s1_char_r;
  logic       s1_fire;
  logic       in_xfer;

  // Result register and pattern overflow flag.
  logic out_valid_r;
  logic out_valid_nxt;
  logic matched_r;
  logic too_long_r;
  logic ovf_r;
  logic ovf_nxt;

  gwm_cmd_t               cmd;
  logic                   full;
  logic                   hit;
  logic [PATTERN_MAX-1:0] valid_v;
  logic [PATTERN_MAX-1:0] star_v;
  logic [PATTERN_MAX-1:0] lit_hit;

  // Only an end-of-subject item needs the result register, so it alone can
  // stall; every other op executes as soon as it sits in the item register.
  assign s1_fire = s1_valid_r
                && ((s1_op_r != OP_END) || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r   <= gwm_op_t'(in_chan.op);
      s1_char_r <= in_chan.character;
    end
  end

  // Op decoder: one command line per executed item.
  always_comb begin
    cmd = '0;
    if (s1_fire) begin
      unique case (s1_op_r)
        OP_CLEAR:   cmd.clear   = 1'b1;
        OP_APPEND:  cmd.append  = 1'b1;
        OP_SUBJECT: cmd.subject = 1'b1;
        OP_END:     cmd.finish  = 1'b1;
        default:    cmd         = '0;
      endcase
    end
  end

  gwm_pattern_bank #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_bank (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .ch      (s1_char_r),
    .full    (full),
    .valid_v (valid_v),
    .star_v  (star_v),
    .lit_hit (lit_hit)
  );

  gwm_active_set #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_active (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .valid_v (valid_v),
    .star_v  (star_v),
    .lit_hit (lit_hit),
    .hit     (hit)
  );

  // An append to a full pattern sets the overflow flag until the next clear.
  always_comb begin
    ovf_nxt = ovf_r;
    if (cmd.clear) begin
      ovf_nxt = 1'b0;
    end else if (cmd.append && full) begin
      ovf_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Overflow forces a miss.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      matched_r  <= hit && !ovf_r;
      too_long_r <= ovf_r;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.matched          = matched_r;
  assign out_chan.pattern_too_long = too_long_r;

  `GWM_ASSERT(a_stall_needs_item, clk, rst_n, !in_chan.ready |-> s1_valid_r, "input stalled with empty item register")
  `GWM_ASSERT(a_result_from_end, clk, rst_n, $rose(out_valid_r) |-> $past(cmd.finish), "result appeared without an end-of-subject item")
  `GWM_ASSERT(a_overflow_misses, clk, rst_n, out_valid_r |-> !(matched_r && too_long_r), "match reported on an overflowed pattern")
  `GWM_ASSERT(a_clear_drops_ovf, clk, rst_n, cmd.clear |=> !ovf_r, "overflow flag survived a clear")

endmodule

FILE: dv/tb_glob_wildcard_matcher_core.sv
// ----------------------------------------------------------------------------
// Glob wildcard matcher core testbench
// Streams pattern loads, subjects and end-of-subject items into the matcher.
// Every transfer runs through a bit-parallel model of the automaton, and each
// result transfer is compared with the oldest predicted verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_glob_wildcard_matcher_core;

  import gwm_pkg::*;

  localparam int unsigned PAT_CAP     = 32;
  localparam int          RANDOM_ITEMS = 1500;
  localparam int          MAX_REPORTS = 10;
  // Transfer counts at which the stress phases kick in.
  localparam int          CALM_FROM   = 300;
  localparam int          CALM_TO     = 550;
  localparam int          HOLD_AT     = 700;
  localparam int          HOLD_CYCLES = 200;
  localparam int          DRAIN_AT    = 1100;
  // Cycles waited at the end of the run, after the wait for the verdicts.
  localparam int          TAIL_CYCLES = 20;
  localparam int          DRAIN_GUARD = 5000;
  // Active set with only position zero live.
  localparam logic [PAT_CAP:0] LIVE_START = {{PAT_CAP{1'b0}}, 1'b1};

  typedef struct packed {
    gwm_op_t    op;
    logic [7:0] character;
  } matcher_item_t;

  typedef struct packed {
    logic matched;
    logic pattern_too_long;
  } verdict_t;

  logic clk;
  logic rst_n;

  gwm_in_if  in_if ();
  gwm_out_if out_if ();

  glob_wildcard_matcher_core #(
    .PATTERN_MAX (PAT_CAP)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Items waiting to be offered, and verdicts waiting for their result transfer.
  matcher_item_t pending_items[$];
  verdict_t      expected_verdicts[$];

  int total_items = 0;
  int n_accepted  = 0;
  int n_errors    = 0;

  // Receiver hold-off state, owned by its own process.
  int hold_left = 0;
  bit hold_done = 1'b0;
  // Set once the sender has paused for a full drain of the result queue.
  bit drain_done = 1'b0;

  // --------------------------------------------------------------------------
  // Matcher model: pattern bytes, length, overflow flag and the active set.
  // The active set is kept without star closure, just like the core keeps it.
  // --------------------------------------------------------------------------
  logic [7:0]       model_pattern [PAT_CAP];
  int unsigned      model_len;
  logic [PAT_CAP:0] model_live;
  logic             model_overflow;

  // Each live star position also enables the position after it. The loop
  // runs upward so that runs of stars cascade in a single pass.
  function automatic logic [PAT_CAP:0] star_closure(logic [PAT_CAP:0] live);
    logic [PAT_CAP:0] closed;
    closed = live;
    for (int i = 0; i < model_len; i++) begin
      if (closed[i] && model_pattern[i] == STAR_BYTE) begin
        closed[i+1] = 1'b1;
      end
    end
    return closed;
  endfunction

  // Applies one accepted item to the model, queuing a verdict for an end item.
  task automatic advance_matcher(matcher_item_t item);
    logic [PAT_CAP:0] cur;
    logic [PAT_CAP:0] nxt;
    verdict_t         v;
    case (item.op)
      OP_CLEAR: begin
        model_len      = 0;
        model_overflow = 1'b0;
        model_live     = LIVE_START;
      end
      OP_APPEND: begin
        // An append at full length stores nothing and marks the overflow.
        if (model_len < PAT_CAP) begin
          model_pattern[model_len] = item.character;
          model_len++;
        end else begin
          model_overflow = 1'b1;
        end
        // Any subject in progress is dropped.
        model_live = LIVE_START;
      end
      OP_SUBJECT: begin
        cur = star_closure(model_live);
        nxt = '0;
        for (int i = 0; i < model_len; i++) begin
          if (cur[i]) begin
            if (model_pattern[i] == STAR_BYTE) begin
              nxt[i] = 1'b1;
            end else if (model_pattern[i] == ANY_BYTE || model_pattern[i] == item.character) begin
              nxt[i+1] = 1'b1;
            end
          end
        end
        model_live = nxt;
      end
      default: begin
        cur                = star_closure(model_live);
        v.matched          = cur[model_len] && !model_overflow;
        v.pattern_too_long = model_overflow;
        expected_verdicts.push_back(v);
        model_live = LIVE_START;
      end
    endcase
  endtask

  task automatic flag_error(string msg);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  task automatic push_item(gwm_op_t op, logic [7:0] character);
    matcher_item_t item;
    item.op        = op;
    item.character = character;
    pending_items.push_back(item);
    total_items++;
  endtask

  // Pattern bytes lean on wildcards and a small alphabet so that matches occur.
  function automatic logic [7:0] pick_pattern_byte();
    int r;
    r = $urandom_range(99);
    if (r < 25) return STAR_BYTE;
    if (r < 40) return ANY_BYTE;
    if (r < 65) return 8'h61;
    if (r < 85) return 8'h62;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] pick_subject_byte();
    int r;
    r = $urandom_range(99);
    if (r < 35) return 8'h61;
    if (r < 65) return 8'h62;
    if (r < 70) return STAR_BYTE;
    if (r < 75) return ANY_BYTE;
    if (r < 80) return 8'h00;
    return 8'($urandom_range(255));
  endfunction

  // One well-formed sequence: clear, load a pattern, then a few subjects.
  // Most subjects are built to fit the pattern, some are mutated, some are
  // noise. Now and then a stray append, clear or missing end breaks a subject.
  task automatic build_sequence(bit force_overflow);
    logic [7:0] gen_pat [PAT_CAP];
    logic [7:0] subj [$];
    logic [7:0] b;
    int         gen_len;
    int         load_len;
    int         r;
    push_item(OP_CLEAR, 8'($urandom_range(255)));
    r = $urandom_range(99);
    if (force_overflow)  load_len = $urandom_range(PAT_CAP + 3, PAT_CAP + 1);
    else if (r < 70)     load_len = $urandom_range(6);
    else if (r < 90)     load_len = $urandom_range(16, 7);
    else if (r < 97)     load_len = $urandom_range(PAT_CAP, 17);
    else                 load_len = $urandom_range(PAT_CAP + 6, PAT_CAP + 1);
    for (int k = 0; k < load_len; k++) begin
      b = pick_pattern_byte();
      push_item(OP_APPEND, b);
      if (k < PAT_CAP) gen_pat[k] = b;
    end
    gen_len = (load_len < PAT_CAP) ? load_len : PAT_CAP;

    repeat ($urandom_range(4, 1)) begin
      subj.delete();
      if ($urandom_range(99) < 55) begin
        for (int i = 0; i < gen_len; i++) begin
          if (gen_pat[i] == STAR_BYTE) begin
            repeat ($urandom_range(3)) subj.push_back(pick_subject_byte());
          end else if (gen_pat[i] == ANY_BYTE) begin
            subj.push_back(8'($urandom_range(255)));
          end else begin
            subj.push_back(gen_pat[i]);
          end
        end
        if (subj.size() > 0 && $urandom_range(99) < 20) begin
          subj[$urandom_range(subj.size() - 1)] = 8'($urandom_range(255));
        end
      end else begin
        repeat ($urandom_range(8)) subj.push_back(pick_subject_byte());
      end

      foreach (subj[i]) begin
        r = $urandom_range(99);
        if (r < 3) begin
          b = pick_pattern_byte();
          push_item(OP_APPEND, b);
          if (gen_len < PAT_CAP) begin
            gen_pat[gen_len] = b;
            gen_len++;
          end
        end else if (r < 5) begin
          push_item(OP_CLEAR, 8'($urandom_range(255)));
          gen_len = 0;
        end
        push_item(OP_SUBJECT, subj[i]);
      end
      if ($urandom_range(99) >= 3) begin
        push_item(OP_END, 8'($urandom_range(255)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Clock and reset. All inputs start at known values; reset is held low from
  // time zero and released with a nonblocking update at a rising edge.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.op         = OP_CLEAR;
    in_if.character  = 8'h00;
    out_if.ready     = 1'b0;
    model_len        = 0;
    model_overflow   = 1'b0;
    model_live       = LIVE_START;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Driver. A transfer at this edge is retired into the model first. A new
  // offer is only made once the previous one has transferred, so valid never
  // drops while an item is on the bus. Random idling is suspended in the calm
  // window, and once the drain point is reached the sender waits until every
  // predicted verdict has been taken.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : item_driver
    bit fire;
    bit offer;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      fire = in_if.valid && in_if.ready;
      if (fire) begin
        advance_matcher(pending_items.pop_front());
        n_accepted++;
      end
      if (!in_if.valid || fire) begin
        offer = pending_items.size() > 0;
        if (!drain_done && n_accepted >= DRAIN_AT) begin
          if (expected_verdicts.size() == 0) drain_done = 1'b1;
          offer = 1'b0;
        end else if (!(n_accepted >= CALM_FROM && n_accepted < CALM_TO) &&
                     $urandom_range(99) < 15) begin
          offer = 1'b0;
        end
        in_if.valid <= offer;
        if (offer) begin
          in_if.op        <= pending_items[0].op;
          in_if.character <= pending_items[0].character;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver hold-off. Once enough items have gone in, ready is held low for
  // a long stretch while the sender keeps offering, so the core backs up.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : hold_counter
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (rst_n && !hold_done && n_accepted >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Each result transfer is matched against the oldest verdict.
  // Case inequality is used so that unknown bits count as mismatches.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    verdict_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_verdicts.size() == 0) begin
          flag_error($sformatf("unexpected result matched=%b pattern_too_long=%b",
                               out_if.matched, out_if.pattern_too_long));
        end else begin
          want = expected_verdicts.pop_front();
          if (out_if.matched !== want.matched ||
              out_if.pattern_too_long !== want.pattern_too_long) begin
            flag_error($sformatf("matched=%b (expected %b) pattern_too_long=%b (expected %b)",
                                 out_if.matched, want.matched,
                                 out_if.pattern_too_long, want.pattern_too_long));
          end
        end
      end
      if (hold_left > 0) begin
        out_if.ready <= 1'b0;
      end else if (n_accepted >= CALM_FROM && n_accepted < CALM_TO) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= 15);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run. A short directed part comes first, then random
  // sequences, the first of which overflows the pattern store.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int guard;
    // Empty pattern against an empty subject, then against one byte.
    push_item(OP_END, 8'hFF);
    push_item(OP_SUBJECT, 8'h61);
    push_item(OP_END, 8'h00);
    // A lone star matches the empty subject.
    push_item(OP_CLEAR, 8'hFF);
    push_item(OP_APPEND, STAR_BYTE);
    push_item(OP_END, 8'hFF);
    // Star then any-byte, fed a zero byte and then two letters.
    push_item(OP_APPEND, ANY_BYTE);
    push_item(OP_SUBJECT, 8'h00);
    push_item(OP_END, 8'h00);
    push_item(OP_SUBJECT, 8'h61);
    push_item(OP_SUBJECT, 8'h62);
    push_item(OP_END, 8'h00);
    // Zero and all-ones literals; an append in the middle of a subject drops it.
    push_item(OP_CLEAR, 8'h00);
    push_item(OP_APPEND, 8'h00);
    push_item(OP_APPEND, 8'hFF);
    push_item(OP_SUBJECT, 8'h00);
    push_item(OP_APPEND, STAR_BYTE);
    push_item(OP_SUBJECT, 8'h00);
    push_item(OP_SUBJECT, 8'hFF);
    push_item(OP_SUBJECT, 8'h78);
    push_item(OP_END, 8'hFF);
    push_item(OP_SUBJECT, 8'h61);
    push_item(OP_END, 8'hFF);

    build_sequence(1'b1);
    while (total_items < RANDOM_ITEMS + 23) begin
      build_sequence(1'b0);
    end

    // Wait for every item to transfer, then for every verdict to come back.
    while (n_accepted < total_items) @(posedge clk);
    guard = 0;
    while (expected_verdicts.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_verdicts.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", expected_verdicts.size()));
    end

    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: ends the run with an error once its delay has passed.
  initial begin : watchdog
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
